### hdl/nitt_pkg.sv
package nitt_pkg;

   localparam int COEF_BITS_DEF = 16;

   localparam int FW = 16;   // field width
   localparam int CW = 17;   // decoded coefficient
   localparam int PW = 34;   // coefficient product
   localparam int KW = 35;   // cofactor
   localparam int VW = 54;   // determinant and transformed vector, signed
   localparam int MW = 53;   // vector magnitude
   localparam int LW = 6;    // bit position in a magnitude
   localparam int AW = 31;   // normalized magnitude
   localparam int QSW = 62;  // square of a normalized magnitude
   localparam int SW = 64;   // sum of squares
   localparam int RW = 32;   // square root
   localparam int NW = 46;   // dividend
   localparam int QW = 15;   // quotient
   localparam int TW = 32;   // threshold register
   localparam int FRAC = 14;
   localparam int UNIT = 16384;
   localparam int NORM_MSB = 30;

   typedef logic signed [CW-1:0] coef_type;
   typedef logic signed [FW-1:0] fld_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [KW-1:0] cof_type;
   typedef logic signed [VW-1:0] vec_type;
   typedef logic [AW-1:0] amag_type;
   typedef logic [QW-1:0] quo_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
      logic       zero;
   } side_type;

   // Operand pairs of the cofactor products: cofactor k = p[2k] - p[2k+1]
   localparam int CF_A [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
   localparam int CF_B [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

   // Take the low bits of the field as a signed value of the given width; above
   // the field width the pattern reads as non-negative.
   function automatic coef_type coef_dec(input logic [FW-1:0] raw, input int bits);
      logic [CW-1:0] ext;
      coef_type      c;
      ext = {1'b0, raw};
      for (int k = 0; k < CW; k++) begin
         if (bits > FW) begin
            c[k] = ext[k];
         end else begin
            c[k] = (k < bits) ? ext[k] : ext[bits-1];
         end
      end
      return c;
   endfunction

endpackage

### hdl/nitt_xform.sv
module nitt_xform #(
   parameter int COEF_BITS = nitt_pkg::COEF_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_vld,
   input  logic [nitt_pkg::FW-1:0]        coef_raw [9],
   input  nitt_pkg::fld_type              nrm_raw [3],
   input  logic [nitt_pkg::TW-1:0]        det_threshold,
   output logic                           out_vld,
   output nitt_pkg::vec_type              vec [3],
   output logic                           degen
);

   logic                 vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff;
   nitt_pkg::coef_type   m1_ff [9];
   nitt_pkg::fld_type    n1_ff [3];
   nitt_pkg::prod_type   cp2_ff [18];
   nitt_pkg::prod_type   fp2_ff [9];
   nitt_pkg::coef_type   r2_ff [3];
   nitt_pkg::fld_type    n2_ff [3];
   nitt_pkg::cof_type    cof3_ff [9];
   nitt_pkg::vec_type    fb3_ff [3];
   nitt_pkg::coef_type   r3_ff [3];
   nitt_pkg::fld_type    n3_ff [3];
   nitt_pkg::vec_type    dp4_ff [3];
   nitt_pkg::vec_type    cn4_ff [9];
   nitt_pkg::vec_type    fb4_ff [3];
   nitt_pkg::vec_type    det5_ff;
   nitt_pkg::vec_type    vi5_ff [3];
   nitt_pkg::vec_type    fb5_ff [3];
   nitt_pkg::vec_type    v6_ff [3];
   logic                 degen6_ff;

   logic [nitt_pkg::VW-1:0] det_mag;
   logic                    degen_in;
   nitt_pkg::vec_type       v_in [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            m1_ff[k] <= nitt_pkg::coef_dec(coef_raw[k], COEF_BITS);
         end
         for (int j = 0; j < 3; j++) begin
            n1_ff[j] <= nrm_raw[j];
         end

         // products for cofactors and for the plain matrix path
         for (int k = 0; k < 18; k++) begin
            cp2_ff[k] <= nitt_pkg::PW'(m1_ff[nitt_pkg::CF_A[k]])
                       * nitt_pkg::PW'(m1_ff[nitt_pkg::CF_B[k]]);
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               fp2_ff[3*i+j] <= nitt_pkg::PW'(m1_ff[3*i+j]) * nitt_pkg::PW'(n1_ff[j]);
            end
            r2_ff[i] <= m1_ff[i];
            n2_ff[i] <= n1_ff[i];
         end

         for (int k = 0; k < 9; k++) begin
            cof3_ff[k] <= nitt_pkg::KW'(cp2_ff[2*k]) - nitt_pkg::KW'(cp2_ff[2*k+1]);
         end
         for (int i = 0; i < 3; i++) begin
            fb3_ff[i] <= nitt_pkg::VW'(fp2_ff[3*i]) + nitt_pkg::VW'(fp2_ff[3*i+1])
                       + nitt_pkg::VW'(fp2_ff[3*i+2]);
            r3_ff[i] <= r2_ff[i];
            n3_ff[i] <= n2_ff[i];
         end

         // determinant terms along row 0, and the adjugate transpose times the normal
         for (int j = 0; j < 3; j++) begin
            dp4_ff[j] <= nitt_pkg::VW'(r3_ff[j]) * nitt_pkg::VW'(cof3_ff[3*j]);
            fb4_ff[j] <= fb3_ff[j];
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               cn4_ff[3*i+j] <= nitt_pkg::VW'(cof3_ff[3*j+i]) * nitt_pkg::VW'(n3_ff[j]);
            end
         end

         det5_ff <= dp4_ff[0] + dp4_ff[1] + dp4_ff[2];
         for (int i = 0; i < 3; i++) begin
            vi5_ff[i] <= cn4_ff[3*i] + cn4_ff[3*i+1] + cn4_ff[3*i+2];
            fb5_ff[i] <= fb4_ff[i];
         end

         degen6_ff <= degen_in;
         for (int i = 0; i < 3; i++) begin
            v6_ff[i] <= v_in[i];
         end
      end
   end

   always_comb begin
      det_mag  = det5_ff[nitt_pkg::VW-1] ? nitt_pkg::VW'(-det5_ff) : nitt_pkg::VW'(det5_ff);
      degen_in = det_mag <= nitt_pkg::VW'(det_threshold);
      for (int i = 0; i < 3; i++) begin
         if (degen_in) begin
            v_in[i] = fb5_ff[i];
         end else if (det5_ff[nitt_pkg::VW-1]) begin
            v_in[i] = -vi5_ff[i];
         end else begin
            v_in[i] = vi5_ff[i];
         end
      end
   end

   assign out_vld = vld6_ff;
   assign degen   = degen6_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec[i] = v6_ff[i];
      end
   end

endmodule

### hdl/nitt_norm.sv
module nitt_norm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  nitt_pkg::vec_type         vec [3],
   input  logic                      degen,
   output logic                      out_vld,
   output logic [nitt_pkg::SW-1:0]   sum,
   output nitt_pkg::amag_type        amag [3],
   output nitt_pkg::side_type        side
);

   logic                      vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   logic [nitt_pkg::MW-1:0]   a1_ff [3];
   nitt_pkg::side_type        side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;
   logic [nitt_pkg::MW-1:0]   a2_ff [3];
   logic [nitt_pkg::LW-1:0]   msb2_ff;
   nitt_pkg::amag_type        a3_ff [3];
   nitt_pkg::amag_type        a4_ff [3];
   logic [nitt_pkg::QSW-1:0]  sq4_ff [3];
   nitt_pkg::amag_type        a5_ff [3];
   logic [nitt_pkg::SW-1:0]   sum5_ff;

   logic [nitt_pkg::MW-1:0]   any_bits;
   logic [nitt_pkg::LW-1:0]   msb_in;
   nitt_pkg::amag_type        sh_in [3];
   nitt_pkg::side_type        side1_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   always_comb begin
      side1_in.degen = degen;
      side1_in.zero  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         side1_in.neg[i] = vec[i][nitt_pkg::VW-1];
      end
   end

   // the top bit of the OR of the magnitudes is the top bit of the largest
   always_comb begin
      any_bits = a1_ff[0] | a1_ff[1] | a1_ff[2];
      msb_in   = '0;
      for (int b = 0; b < nitt_pkg::MW; b++) begin
         if (any_bits[b]) begin
            msb_in = nitt_pkg::LW'(b);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (msb2_ff >= nitt_pkg::LW'(nitt_pkg::NORM_MSB)) begin
            sh_in[i] = nitt_pkg::AW'(a2_ff[i] >> (msb2_ff - nitt_pkg::LW'(nitt_pkg::NORM_MSB)));
         end else begin
            sh_in[i] = nitt_pkg::AW'(a2_ff[i] << (nitt_pkg::LW'(nitt_pkg::NORM_MSB) - msb2_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= side1_in;
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= vec[i][nitt_pkg::VW-1] ? nitt_pkg::MW'(-vec[i]) : nitt_pkg::MW'(vec[i]);
         end

         msb2_ff  <= msb_in;
         side2_ff <= {side1_ff.neg, side1_ff.degen, (any_bits == '0)};
         for (int i = 0; i < 3; i++) begin
            a2_ff[i] <= a1_ff[i];
         end

         side3_ff <= side2_ff;
         for (int i = 0; i < 3; i++) begin
            a3_ff[i] <= sh_in[i];
         end

         side4_ff <= side3_ff;
         for (int i = 0; i < 3; i++) begin
            a4_ff[i]  <= a3_ff[i];
            sq4_ff[i] <= nitt_pkg::QSW'(a3_ff[i]) * nitt_pkg::QSW'(a3_ff[i]);
         end

         side5_ff <= side4_ff;
         sum5_ff  <= nitt_pkg::SW'(sq4_ff[0]) + nitt_pkg::SW'(sq4_ff[1])
                   + nitt_pkg::SW'(sq4_ff[2]);
         for (int i = 0; i < 3; i++) begin
            a5_ff[i] <= a4_ff[i];
         end
      end
   end

   assign out_vld = vld5_ff;
   assign sum     = sum5_ff;
   assign side    = side5_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         amag[i] = a5_ff[i];
      end
   end

endmodule

### hdl/nitt_sqrt.sv
module nitt_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  logic [nitt_pkg::SW-1:0]   sum,
   input  nitt_pkg::amag_type        amag_in [3],
   input  nitt_pkg::side_type        side_in,
   output logic                      out_vld,
   output logic [nitt_pkg::RW-1:0]   root,
   output nitt_pkg::amag_type        amag_out [3],
   output nitt_pkg::side_type        side_out
);

   localparam int STG = nitt_pkg::RW;

   logic                      vld_ff  [STG];
   logic [nitt_pkg::SW-1:0]   rem_ff  [STG];
   logic [nitt_pkg::SW-1:0]   res_ff  [STG];
   nitt_pkg::amag_type        a_ff    [STG][3];
   nitt_pkg::side_type        side_ff [STG];

   // one result bit per stage, from the top down
   for (genvar k = 0; k < STG; k++) begin : g_step
      localparam logic [nitt_pkg::SW-1:0] BIT = nitt_pkg::SW'(1) << (nitt_pkg::SW - 2 - 2*k);

      logic                      vld_prev;
      logic [nitt_pkg::SW-1:0]   rem_prev, res_prev, trial, rem_in, res_in;
      nitt_pkg::amag_type        a_prev [3];
      nitt_pkg::side_type        side_prev;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = sum;
         assign res_prev  = '0;
         assign side_prev = side_in;
         assign a_prev    = amag_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign res_prev  = res_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign a_prev    = a_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_prev;
            a_ff[k]    <= a_prev;
         end
      end
   end

   assign out_vld  = vld_ff[STG-1];
   assign root     = res_ff[STG-1][nitt_pkg::RW-1:0];
   assign side_out = side_ff[STG-1];
   assign amag_out = a_ff[STG-1];

endmodule

### hdl/nitt_div.sv
module nitt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  logic [nitt_pkg::RW-1:0]   root,
   input  nitt_pkg::amag_type        amag [3],
   input  nitt_pkg::side_type        side_in,
   output logic                      out_vld,
   output nitt_pkg::quo_type         quo [3],
   output nitt_pkg::side_type        side_out
);

   localparam int STG = nitt_pkg::QW;

   logic                      vld0_ff;
   logic [nitt_pkg::RW-1:0]   d0_ff;
   logic [nitt_pkg::NW-1:0]   n0_ff [3];
   nitt_pkg::side_type        side0_ff;
   logic [nitt_pkg::RW-1:0]   root_eff;

   logic                      vld_ff  [STG];
   logic [nitt_pkg::RW-1:0]   d_ff    [STG];
   logic [nitt_pkg::NW-1:0]   n_ff    [STG][3];
   nitt_pkg::quo_type         q_ff    [STG][3];
   nitt_pkg::side_type        side_ff [STG];

   assign root_eff = (root == '0) ? nitt_pkg::RW'(1) : root;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= in_vld;
      end
   end

   // dividend carries half the divisor so the quotient rounds to nearest
   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff    <= root_eff;
         side0_ff <= side_in;
         for (int i = 0; i < 3; i++) begin
            n0_ff[i] <= (nitt_pkg::NW'(amag[i]) << nitt_pkg::FRAC)
                      + nitt_pkg::NW'(root_eff >> 1);
         end
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < STG; k++) begin : g_step
      localparam int SH = STG - 1 - k;

      logic                      vld_prev;
      logic [nitt_pkg::RW-1:0]   d_prev;
      logic [nitt_pkg::NW-1:0]   n_prev [3];
      logic [nitt_pkg::NW-1:0]   n_in   [3];
      nitt_pkg::quo_type         q_prev [3];
      nitt_pkg::quo_type         q_in   [3];
      nitt_pkg::side_type        side_prev;
      logic [nitt_pkg::NW-1:0]   trial;

      if (k == 0) begin : g_first
         assign vld_prev  = vld0_ff;
         assign d_prev    = d0_ff;
         assign n_prev    = n0_ff;
         assign q_prev    = '{default: '0};
         assign side_prev = side0_ff;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign d_prev    = d_ff[k-1];
         assign n_prev    = n_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         trial = nitt_pkg::NW'(d_prev) << SH;
         for (int i = 0; i < 3; i++) begin
            q_in[i] = q_prev[i];
            if (n_prev[i] >= trial) begin
               n_in[i]     = n_prev[i] - trial;
               q_in[i][SH] = 1'b1;
            end else begin
               n_in[i] = n_prev[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[k]    <= d_prev;
            n_ff[k]    <= n_in;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[STG-1];
   assign quo      = q_ff[STG-1];
   assign side_out = side_ff[STG-1];

endmodule

### hdl/normal_inverse_transpose_transform.sv
// Transforms a surface normal by the inverse transpose of a 3x3 Q4.12 matrix and
// returns it scaled to unit length in Q2.14; when the determinant's magnitude is
// at or below csr_det_threshold (units of 2^-36), the plain matrix is used and
// rsp_degenerate is set, and a zero vector returns zero. One transfer is accepted
// per clock while the pipeline advances. The path runs through a 6-stage multiply
// pipeline for the cofactors and determinant, 5 stages of normalization and sum of
// squares, a 32-stage square root (one root bit per stage), a 16-stage divider (an
// input stage, then one quotient bit per stage per component) and the output
// register. The whole pipeline holds while a result waits on rsp_ready.
module normal_inverse_transpose_transform #(
   parameter int COEF_BITS = nitt_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_m00,
   input  logic signed [15:0]            req_m01,
   input  logic signed [15:0]            req_m02,
   input  logic signed [15:0]            req_m10,
   input  logic signed [15:0]            req_m11,
   input  logic signed [15:0]            req_m12,
   input  logic signed [15:0]            req_m20,
   input  logic signed [15:0]            req_m21,
   input  logic signed [15:0]            req_m22,
   input  logic signed [15:0]            req_normal_x,
   input  logic signed [15:0]            req_normal_y,
   input  logic signed [15:0]            req_normal_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [15:0]            rsp_out_x,
   output logic signed [15:0]            rsp_out_y,
   output logic signed [15:0]            rsp_out_z,
   output logic                          rsp_degenerate,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_det_threshold
);

   logic                        adv;
   logic [nitt_pkg::TW-1:0]     det_threshold_ff;
   logic [nitt_pkg::FW-1:0]     coef_raw [9];
   nitt_pkg::fld_type           nrm_raw [3];

   logic                        xf_vld, xf_degen;
   nitt_pkg::vec_type           xf_vec [3];
   logic                        nm_vld;
   logic [nitt_pkg::SW-1:0]     nm_sum;
   nitt_pkg::amag_type          nm_amag [3];
   nitt_pkg::side_type          nm_side;
   logic                        sq_vld;
   logic [nitt_pkg::RW-1:0]     sq_root;
   nitt_pkg::amag_type          sq_amag [3];
   nitt_pkg::side_type          sq_side;
   logic                        dv_vld;
   nitt_pkg::quo_type           dv_quo [3];
   nitt_pkg::side_type          dv_side;

   logic                        rsp_valid_ff;
   nitt_pkg::fld_type           out_ff [3];
   nitt_pkg::fld_type           out_in [3];
   logic                        degen_ff;
   nitt_pkg::quo_type           q_sat;

   // advance every stage when the output register is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_threshold_ff <= nitt_pkg::TW'(1);
      end else if (csr_valid) begin
         det_threshold_ff <= csr_det_threshold;
      end
   end

   assign coef_raw = '{req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
                       req_m20, req_m21, req_m22};
   assign nrm_raw  = '{req_normal_x, req_normal_y, req_normal_z};

   nitt_xform #(.COEF_BITS(COEF_BITS)) u_xform (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_vld        (req_valid),
      .coef_raw      (coef_raw),
      .nrm_raw       (nrm_raw),
      .det_threshold (det_threshold_ff),
      .out_vld       (xf_vld),
      .vec           (xf_vec),
      .degen         (xf_degen)
   );

   nitt_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (xf_vld),
      .vec     (xf_vec),
      .degen   (xf_degen),
      .out_vld (nm_vld),
      .sum     (nm_sum),
      .amag    (nm_amag),
      .side    (nm_side)
   );

   nitt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (nm_vld),
      .sum      (nm_sum),
      .amag_in  (nm_amag),
      .side_in  (nm_side),
      .out_vld  (sq_vld),
      .root     (sq_root),
      .amag_out (sq_amag),
      .side_out (sq_side)
   );

   nitt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (sq_vld),
      .root     (sq_root),
      .amag     (sq_amag),
      .side_in  (sq_side),
      .out_vld  (dv_vld),
      .quo      (dv_quo),
      .side_out (dv_side)
   );

   // clamp to unit length, restore signs; force zero for a zero vector
   always_comb begin
      q_sat = '0;
      for (int i = 0; i < 3; i++) begin
         q_sat = (dv_quo[i] > nitt_pkg::QW'(nitt_pkg::UNIT)) ? nitt_pkg::QW'(nitt_pkg::UNIT)
                                                             : dv_quo[i];
         if (dv_side.zero) begin
            out_in[i] = '0;
         end else if (dv_side.neg[i]) begin
            out_in[i] = -nitt_pkg::FW'(q_sat);
         end else begin
            out_in[i] = nitt_pkg::FW'(q_sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff   <= out_in;
         degen_ff <= dv_side.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_ff[0];
   assign rsp_out_y      = out_ff[1];
   assign rsp_out_z      = out_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule
